[hw/rtl/assert_macros.svh]
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, inactive while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check: cause now implies effect in the next cycle.
`define ASSERT_NEXT(label, cause, effect, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

[hw/rtl/u8dec_pkg.sv]
// Shared types and constants of the UTF-8 to UCS-2 decoder.
`timescale 1ns / 1ps

package u8dec_pkg;

    localparam int unsigned UNIT_W      = 16;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [UNIT_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [UNIT_W-1:0] BUFFER_LENGTH_RST = 16'd256;

    // Continuation bytes still awaited.
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_ONE  = 2'd1;
    localparam logic [1:0] PEND_TWO  = 2'd2;

    // APB register map
    localparam int unsigned PADDR_W = 2;
    localparam logic [PADDR_W-1:0] ADDR_BUFFER_LENGTH = 2'd0;

    // One queue entry: replacement units first, then an optional tail result
    // (a decoded unit, or the terminator whose value is the unit count).
    typedef struct packed {
        logic [1:0]        rep_count;
        logic              has_tail;
        logic              tail_eos;
        logic [UNIT_W-1:0] tail_value;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

[hw/rtl/u8dec_if.sv]
// Stream interfaces: input bytes and result code units.
`timescale 1ns / 1ps

interface u8dec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8dec_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_string;
    logic [15:0] units_written;
    logic        last;

    modport source (output valid, output code_unit, output end_of_string,
                    output units_written, output last, input ready);
    modport sink   (input valid, input code_unit, input end_of_string,
                    input units_written, input last, output ready);
endinterface

[hw/rtl/utf8_to_ucs2_decoder.sv]
// UTF-8 to UCS-2 decoder: bytes of a zero-terminated string in, BMP code units
// out, one transaction per unit. The input takes one byte per clock cycle as long
// as the 4-entry result queue has room; each byte yields zero to three results,
// and the output sends one result per cycle while out_ch.ready is high, so a byte
// with several results holds the output until all are sent. Sustained rate: one
// byte per cycle when each byte gives at most one result and out_ch stays ready;
// bursts (broken sequences) queue and back-pressure the input only once it fills.
// Two- and three-byte sequences are decoded without range checks (overlong forms
// and surrogates pass); broken sequences give U+FFFD for the lead and any held
// middle byte, then the breaking byte is decoded as a fresh lead. At most
// buffer_length-1 units are sent per string; the terminator result (code 0,
// end_of_string set) carries the count in units_written. buffer_length sits at APB
// byte address 0 and should only be written while the block is idle.
`timescale 1ns / 1ps

module utf8_to_ucs2_decoder
    import u8dec_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    u8dec_byte_if.sink         in_ch,
    u8dec_unit_if.source       out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [UNIT_W-1:0] buffer_length_reg;
    q_push_t           q_push;
    q_status_t         q_status;
    entry_t            head;
    logic              pop;

    // config register, zero-wait-state access phase (pready tied high)
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUFFER_LENGTH) ? {16'b0, buffer_length_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            buffer_length_reg <= BUFFER_LENGTH_RST;
        else if (psel && penable && pwrite && pready && (paddr == ADDR_BUFFER_LENGTH))
            buffer_length_reg <= pwdata[UNIT_W-1:0];
    end

    // front end: byte classification and sequence state
    u8dec_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .buffer_length (buffer_length_reg),
        .q_status      (q_status),
        .q_push        (q_push)
    );

    // decouples byte intake from result delivery
    u8dec_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_push   (q_push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    // back end: one result transaction per cycle while out_ch.ready is high
    u8dec_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

[hw/rtl/u8dec_front.sv]
// Front end: accepts bytes, tracks sequence state, builds at most one queue entry per byte.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_front
    import u8dec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    u8dec_byte_if.sink        in_ch,
    input  logic [UNIT_W-1:0] buffer_length,
    input  q_status_t         q_status,
    output q_push_t           q_push
);

    logic [7:0]        lead_reg, lead_next;
    logic [7:0]        middle_reg, middle_next;
    logic [1:0]        pending_reg, pending_next;
    logic [UNIT_W-1:0] count_reg, count_next;

    logic              fire;
    logic [7:0]        b;
    logic              is_cont;
    logic              two;
    logic [UNIT_W-1:0] cap;
    logic              room0;
    logic              room1;
    logic [1:0]        rep_emit;
    logic [UNIT_W-1:0] cnt1;
    logic [UNIT_W-1:0] code2;
    logic [UNIT_W-1:0] code3;
    entry_t            entry;

    assign in_ch.ready = !q_status.full;
    assign fire        = in_ch.valid && !q_status.full;
    assign b           = in_ch.data_byte;
    assign is_cont     = (b[7:6] == 2'b10);
    assign two         = (lead_reg[7:5] == 3'b110);
    assign cap         = (buffer_length == '0) ? '0 : buffer_length - 16'd1;
    assign room0       = (count_reg < cap);
    assign room1       = ({1'b0, count_reg} + 17'd1) < {1'b0, cap};
    assign code2       = {5'b0, lead_reg[4:0], b[5:0]};
    assign code3       = {lead_reg[3:0], middle_reg[5:0], b[5:0]};

    always_comb
    begin
        lead_next    = lead_reg;
        middle_next  = middle_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        entry        = '0;
        rep_emit     = 2'd0;
        cnt1         = count_reg;
        if (fire)
        begin
            if ((pending_reg != PEND_NONE) && is_cont)
            begin
                if (two)
                begin
                    pending_next = PEND_NONE;
                    if (room0)
                    begin
                        entry.has_tail   = 1'b1;
                        entry.tail_value = code2;
                        count_next       = count_reg + 16'd1;
                    end
                end
                else if (pending_reg == PEND_TWO)
                begin
                    middle_next  = b;
                    pending_next = PEND_ONE;
                end
                else
                begin
                    pending_next = PEND_NONE;
                    if (room0)
                    begin
                        entry.has_tail   = 1'b1;
                        entry.tail_value = code3;
                        count_next       = count_reg + 16'd1;
                    end
                end
            end
            else
            begin
                // broken sequence: one replacement for the lead, one more for a held middle
                if (pending_reg != PEND_NONE)
                begin
                    if (!two && (pending_reg == PEND_ONE))
                        rep_emit = {1'b0, room0} + {1'b0, room1};
                    else
                        rep_emit = {1'b0, room0};
                end
                cnt1            = count_reg + {14'b0, rep_emit};
                entry.rep_count = rep_emit;
                pending_next    = PEND_NONE;
                count_next      = cnt1;
                if (b == 8'h00)
                begin
                    entry.has_tail   = 1'b1;
                    entry.tail_eos   = 1'b1;
                    entry.tail_value = cnt1;
                    lead_next        = '0;
                    middle_next      = '0;
                    count_next       = '0;
                end
                else if (cnt1 < cap)
                begin
                    if (b[7] == 1'b0)
                    begin
                        entry.has_tail   = 1'b1;
                        entry.tail_value = {8'b0, b};
                        count_next       = cnt1 + 16'd1;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        lead_next    = b;
                        pending_next = PEND_ONE;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        lead_next    = b;
                        pending_next = PEND_TWO;
                    end
                    else
                    begin
                        entry.has_tail   = 1'b1;
                        entry.tail_value = REPLACEMENT_CHAR;
                        count_next       = cnt1 + 16'd1;
                    end
                end
            end
        end
    end

    assign q_push.push  = fire && ((entry.rep_count != 2'd0) || entry.has_tail);
    assign q_push.entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg    <= '0;
            middle_reg  <= '0;
            pending_reg <= PEND_NONE;
            count_reg   <= '0;
        end
        else
        begin
            lead_reg    <= lead_next;
            middle_reg  <= middle_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

    `ASSERT_CLK(a_pending_legal, pending_reg != 2'd3, "pending count out of range")
    `ASSERT_NEXT(a_eos_clears, q_push.push && q_push.entry.tail_eos, (count_reg == '0) && (pending_reg == PEND_NONE), "state not cleared after terminator")

endmodule

[hw/rtl/u8dec_queue.sv]
// Small entry queue between the front end and the result sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_queue
    import u8dec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_push_t   q_push,
    input  logic      pop,
    output q_status_t q_status,
    output entry_t    head
);

    entry_t            entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (q_push.push)
            entries_reg[wr_ptr_reg] <= q_push.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push.push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            case ({q_push.push, pop})
                2'b10:   count_reg <= count_reg + QCNT_W'(1);
                2'b01:   count_reg <= count_reg - QCNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    `ASSERT_CLK(a_no_overflow, !(q_push.push && q_status.full), "push into full queue")
    `ASSERT_CLK(a_no_underflow, !(pop && q_status.empty), "pop from empty queue")

endmodule

[hw/rtl/u8dec_back.sv]
// Back end: walks each queue entry and sends its results one transaction at a time.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module u8dec_back
    import u8dec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_status_t    q_status,
    input  entry_t       head,
    output logic         pop,
    u8dec_unit_if.source out_ch
);

    logic [1:0] pos_reg, pos_next;
    logic [1:0] total;
    logic       is_rep;
    logic       is_last;
    logic       fire;

    assign total   = head.rep_count + {1'b0, head.has_tail};
    assign is_rep  = (pos_reg < head.rep_count);
    assign is_last = (pos_reg == (total - 2'd1));
    assign fire    = out_ch.valid && out_ch.ready;
    assign pop     = fire && is_last;

    assign out_ch.valid         = !q_status.empty;
    assign out_ch.code_unit     = is_rep ? REPLACEMENT_CHAR :
                                  (head.tail_eos ? '0 : head.tail_value);
    assign out_ch.end_of_string = !is_rep && head.tail_eos;
    assign out_ch.units_written = (!is_rep && head.tail_eos) ? head.tail_value : '0;
    assign out_ch.last          = is_last;

    always_comb
    begin
        pos_next = pos_reg;
        if (fire)
            pos_next = is_last ? 2'd0 : pos_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    `ASSERT_CLK(a_entry_nonempty, q_status.empty || (total != 2'd0), "queued entry carries no result")
    `ASSERT_CLK(a_pos_in_range, q_status.empty || (pos_reg < total), "result index past entry end")

endmodule
